### hw/rtl/cpws_pkg.sv
// Package: shared types, codes and reset constants of the command pulse and wake sequencer.
`default_nettype none

package cpws_pkg;

   // Default countdown width
   localparam int COUNT_BITS_DEFAULT = 16;

   // Configuration register width and index width of the register port
   localparam int CSR_DATA_BITS  = 16;
   localparam int CSR_INDEX_BITS = 3;

   // Reset values of the configuration registers
   localparam logic [CSR_DATA_BITS-1:0] WAKE_HIGH_RESET     = 16'd60;
   localparam logic [CSR_DATA_BITS-1:0] WAKE_LOW_RESET      = 16'd2500;
   localparam logic [CSR_DATA_BITS-1:0] COMMAND_PULSE_RESET = 16'd1000;
   localparam logic [CSR_DATA_BITS-1:0] RESUME_DELAY_RESET  = 16'd2000;

   // Line numbers within the level vector
   localparam int LINE_OPEN      = 0;
   localparam int LINE_CLOSE     = 1;
   localparam int LINE_AUTOCLOSE = 2;
   localparam int LINE_COUNT     = 3;

   typedef enum logic {
      REQ_TICK    = 1'b0,
      REQ_COMMAND = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      CMD_OPEN      = 2'd0,
      CMD_CLOSE     = 2'd1,
      CMD_AUTOCLOSE = 2'd2,
      CMD_BAD       = 2'd3
   } cmd_code_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_WAKE_HIGH     = 3'd0,
      CSR_WAKE_LOW      = 3'd1,
      CSR_COMMAND_PULSE = 3'd2,
      CSR_RESUME_DELAY  = 3'd3
   } csr_index_type;

   // Configuration as seen by the sequencer core
   typedef struct packed {
      logic [CSR_DATA_BITS-1:0] wake_high_ms;
      logic [CSR_DATA_BITS-1:0] wake_low_ms;
      logic [CSR_DATA_BITS-1:0] command_pulse_ms;
      logic [CSR_DATA_BITS-1:0] resume_delay_ms;
   } cfg_type;

   // One result beat
   typedef struct packed {
      logic open_level;
      logic close_level;
      logic autoclose_level;
      logic rejected;
   } rsp_type;

endpackage

`default_nettype wire

### hw/rtl/cpws_csr.sv
// Configuration register file of the command pulse and wake sequencer.
`default_nettype none

module cpws_csr
   import cpws_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_write,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output cfg_type                        cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write; indexes beyond the list are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_WAKE_HIGH:     cfg_in.wake_high_ms     = csr_wdata;
            CSR_WAKE_LOW:      cfg_in.wake_low_ms      = csr_wdata;
            CSR_COMMAND_PULSE: cfg_in.command_pulse_ms = csr_wdata;
            CSR_RESUME_DELAY:  cfg_in.resume_delay_ms  = csr_wdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wake_high_ms     <= WAKE_HIGH_RESET;
         cfg_ff.wake_low_ms      <= WAKE_LOW_RESET;
         cfg_ff.command_pulse_ms <= COMMAND_PULSE_RESET;
         cfg_ff.resume_delay_ms  <= RESUME_DELAY_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

### hw/rtl/cpws_core.sv
// Sequencer core: wake timer, command pulse timer and the three line levels.
`default_nettype none

module cpws_core
   import cpws_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
)
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         step,
   input  wire logic         item_kind,
   input  wire logic [1:0]   item_code,
   input  wire cfg_type      cfg,
   output rsp_type           result
);

   localparam logic [COUNT_BITS-1:0] CountOne = COUNT_BITS'(1);

   logic [COUNT_BITS-1:0] wake_count_ff, wake_count_in;
   logic                  wake_armed_ff, wake_armed_in;
   logic                  wake_phase_ff, wake_phase_in;
   logic [COUNT_BITS-1:0] pulse_count_ff, pulse_count_in;
   logic                  pulse_active_ff, pulse_active_in;
   logic [1:0]            pulse_line_ff, pulse_line_in;
   logic [LINE_COUNT-1:0] levels_ff, levels_in;
   logic                  rejected;

   // Next state for the item in the input register
   always_comb begin
      wake_count_in   = wake_count_ff;
      wake_armed_in   = wake_armed_ff;
      wake_phase_in   = wake_phase_ff;
      pulse_count_in  = pulse_count_ff;
      pulse_active_in = pulse_active_ff;
      pulse_line_in   = pulse_line_ff;
      levels_in       = levels_ff;
      rejected        = 1'b0;
      if (req_kind_type'(item_kind) == REQ_COMMAND) begin
         if (cmd_code_type'(item_code) == CMD_BAD) begin
            rejected = 1'b1;
         end else begin
            // valid command: stop wake timer, restart pulse on the chosen line
            wake_armed_in         = 1'b0;
            pulse_line_in         = item_code;
            pulse_active_in       = 1'b1;
            pulse_count_in        = COUNT_BITS'(cfg.command_pulse_ms);
            levels_in[item_code]  = 1'b1;
         end
      end else if (wake_armed_ff) begin
         if (wake_count_ff <= CountOne) begin
            // wake expiry: drive phase onto close, toggle, reload
            levels_in[LINE_CLOSE] = wake_phase_ff;
            wake_phase_in         = !wake_phase_ff;
            wake_count_in         = wake_phase_ff ? COUNT_BITS'(cfg.wake_high_ms)
                                                  : COUNT_BITS'(cfg.wake_low_ms);
         end else begin
            wake_count_in = wake_count_ff - CountOne;
         end
      end else if (pulse_active_ff) begin
         if (pulse_count_ff <= CountOne) begin
            // pulse ends: drop the line and re-arm wake with the resume delay
            levels_in[pulse_line_ff] = 1'b0;
            pulse_active_in          = 1'b0;
            pulse_count_in           = '0;
            wake_armed_in            = 1'b1;
            wake_count_in            = COUNT_BITS'(cfg.resume_delay_ms);
         end else begin
            pulse_count_in = pulse_count_ff - CountOne;
         end
      end
   end

   // State registers, updated only when the beat moves to the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         wake_count_ff   <= COUNT_BITS'(WAKE_LOW_RESET);
         wake_armed_ff   <= 1'b1;
         wake_phase_ff   <= 1'b0;
         pulse_count_ff  <= '0;
         pulse_active_ff <= 1'b0;
         pulse_line_ff   <= '0;
         levels_ff       <= '0;
      end else if (step) begin
         wake_count_ff   <= wake_count_in;
         wake_armed_ff   <= wake_armed_in;
         wake_phase_ff   <= wake_phase_in;
         pulse_count_ff  <= pulse_count_in;
         pulse_active_ff <= pulse_active_in;
         pulse_line_ff   <= pulse_line_in;
         levels_ff       <= levels_in;
      end
   end

   assign result.open_level      = levels_in[LINE_OPEN];
   assign result.close_level     = levels_in[LINE_CLOSE];
   assign result.autoclose_level = levels_in[LINE_AUTOCLOSE];
   assign result.rejected        = rejected;

   // Exactly one of the two timers runs at any time
   a_one_timer: assert property (@(posedge clock) disable iff (reset)
      wake_armed_ff != pulse_active_ff)
      else $error("wake and pulse timers both running or both stopped");

   // The line of a pulse in flight is held high
   a_pulse_line_high: assert property (@(posedge clock) disable iff (reset)
      pulse_active_ff |->
         ((pulse_line_ff == CMD_OPEN      && levels_ff[LINE_OPEN])  ||
          (pulse_line_ff == CMD_CLOSE     && levels_ff[LINE_CLOSE]) ||
          (pulse_line_ff == CMD_AUTOCLOSE && levels_ff[LINE_AUTOCLOSE])))
      else $error("command pulse line not high");

   // A rejected command leaves all state alone
   a_reject_no_change: assert property (@(posedge clock) disable iff (reset)
      (step && rejected) |=>
         ($stable(levels_ff) && $stable(wake_count_ff) && $stable(pulse_count_ff) &&
          $stable(wake_armed_ff) && $stable(wake_phase_ff)))
      else $error("rejected command changed state");

   // A valid command always starts a pulse
   a_command_starts_pulse: assert property (@(posedge clock) disable iff (reset)
      (step && item_kind == REQ_COMMAND && !rejected) |=>
         (pulse_active_ff && !wake_armed_ff))
      else $error("valid command did not start a pulse");

endmodule

`default_nettype wire

### hw/rtl/command_pulse_and_wake_sequencer.sv
// A request beat is registered, then its result is registered and drives rsp_valid.
// Throughput: one request per cycle; the single-pass update of the two countdowns sets this.
// A result held by rsp_ready low stalls the request register; req_ready drops once both are full.
// Reset (synchronous, active high): close line wake timer armed with the low time, no pulse,
// all lines low, configuration back to 60 / 2500 / 1000 / 2000 ms, both stages empty.
// Top level of the command pulse and wake sequencer.
`default_nettype none

module command_pulse_and_wake_sequencer
   import cpws_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
)
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   // request channel
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic                      req_type,
   input  wire logic [1:0]                req_command_code,
   // result channel
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic                           rsp_open_level,
   output logic                           rsp_close_level,
   output logic                           rsp_autoclose_level,
   output logic                           rsp_rejected,
   // configuration channel
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   logic       in_valid_ff, in_valid_in;
   logic       in_kind_ff;
   logic [1:0] in_code_ff;
   logic       out_valid_ff, out_valid_in;
   rsp_type    out_data_ff;
   rsp_type    core_result;
   cfg_type    cfg;
   logic       advance;

   // Configuration is always taken
   assign csr_ready = 1'b1;

   cpws_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Beat moves from the request register to the result register
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   cpws_core #(
      .COUNT_BITS (COUNT_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .item_kind (in_kind_ff),
      .item_code (in_code_ff),
      .cfg       (cfg),
      .result    (core_result)
   );

   // Stage valids
   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_kind_ff <= req_type;
         in_code_ff <= req_command_code;
      end
      if (advance) begin
         out_data_ff <= core_result;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_open_level      = out_data_ff.open_level;
   assign rsp_close_level     = out_data_ff.close_level;
   assign rsp_autoclose_level = out_data_ff.autoclose_level;
   assign rsp_rejected        = out_data_ff.rejected;

endmodule

`default_nettype wire

### tb/sv/command_pulse_and_wake_sequencer_tb.sv
// Testbench: checks open, close and autoclose levels and rejects of the command pulse and wake sequencer.
`timescale 1ns / 100ps

module command_pulse_and_wake_sequencer_tb;
   import cpws_pkg::*;

   // Register indexes with no register behind them
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNMAPPED_LO = CSR_RESUME_DELAY + 1'b1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNMAPPED_HI = '1;
   localparam logic [CSR_DATA_BITS-1:0]  DURATION_MAX    = '1;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic                      req_type;
   logic [1:0]                req_command_code;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic                      rsp_open_level;
   logic                      rsp_close_level;
   logic                      rsp_autoclose_level;
   logic                      rsp_rejected;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   // Own copy of the sequencer state and its registers
   cfg_type                        cfg;
   logic [COUNT_BITS_DEFAULT-1:0]  wake_count;
   logic                           wake_armed;
   logic                           wake_phase;
   logic [COUNT_BITS_DEFAULT-1:0]  pulse_count;
   logic                           pulse_active;
   logic [1:0]                     pulse_line;
   logic [LINE_COUNT-1:0]          levels;

   rsp_type     levels_due_q[$];
   int unsigned failures;
   int unsigned beats_sent;
   int unsigned beats_checked;
   int unsigned req_stalls;
   int unsigned settings_applied;

   // Receiver pacing controls
   int          rsp_hold_request;
   logic        rsp_stalls_on;

   command_pulse_and_wake_sequencer i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_type            (req_type),
      .req_command_code    (req_command_code),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_open_level      (rsp_open_level),
      .rsp_close_level     (rsp_close_level),
      .rsp_autoclose_level (rsp_autoclose_level),
      .rsp_rejected        (rsp_rejected),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   // 50 MHz clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Line levels after one beat; updates the sequencer state copy
   function automatic rsp_type next_line_levels(input req_kind_type kind,
                                                input cmd_code_type code);
      rsp_type r;
      r.rejected = 1'b0;
      if (kind == REQ_COMMAND) begin
         if (code == CMD_BAD) begin
            r.rejected = 1'b1;
         end else begin
            // old pulse abandoned, its line keeps its level
            wake_armed   = 1'b0;
            pulse_line   = code;
            pulse_active = 1'b1;
            pulse_count  = cfg.command_pulse_ms;
            levels[code] = 1'b1;
         end
      end else if (wake_armed) begin
         if (wake_count <= 1) begin
            levels[LINE_CLOSE] = wake_phase;
            wake_phase = !wake_phase;
            wake_count = wake_phase ? cfg.wake_low_ms : cfg.wake_high_ms;
         end else begin
            wake_count = wake_count - 1'b1;
         end
      end else if (pulse_active) begin
         if (pulse_count <= 1) begin
            levels[pulse_line] = 1'b0;
            pulse_active = 1'b0;
            pulse_count  = '0;
            wake_armed   = 1'b1;
            wake_count   = cfg.resume_delay_ms;
         end else begin
            pulse_count = pulse_count - 1'b1;
         end
      end
      r.open_level      = levels[LINE_OPEN];
      r.close_level     = levels[LINE_CLOSE];
      r.autoclose_level = levels[LINE_AUTOCLOSE];
      return r;
   endfunction

   // Offer one request beat and hold it until taken
   task automatic send_beat(input req_kind_type kind, input cmd_code_type code);
      @(negedge clock);
      req_valid        <= 1'b1;
      req_type         <= kind;
      req_command_code <= code;
      @(posedge clock);
      while (!req_ready) begin
         req_stalls++;
         @(posedge clock);
      end
      levels_due_q.push_back(next_line_levels(kind, code));
      beats_sent++;
   endtask

   // Request channel idle, payload scrambled
   task automatic idle_cycles(input int n);
      repeat (n) begin
         @(negedge clock);
         req_valid        <= 1'b0;
         req_type         <= 1'($urandom);
         req_command_code <= 2'($urandom);
      end
   endtask

   // Sender pauses until every outstanding result is back
   task automatic wait_for_results();
      idle_cycles(1);
      while (levels_due_q.size() != 0)
         @(posedge clock);
      idle_cycles(3);
   endtask

   // Register write; only called with the block idle
   task automatic csr_write(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      case (idx)
         CSR_WAKE_HIGH:     cfg.wake_high_ms     = data;
         CSR_WAKE_LOW:      cfg.wake_low_ms      = data;
         CSR_COMMAND_PULSE: cfg.command_pulse_ms = data;
         CSR_RESUME_DELAY:  cfg.resume_delay_ms  = data;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
      csr_wdata <= 16'($urandom);
   endtask

   // All four registers to one value
   task automatic csr_write_all(input logic [CSR_DATA_BITS-1:0] data);
      csr_write(CSR_WAKE_HIGH, data);
      csr_write(CSR_WAKE_LOW, data);
      csr_write(CSR_COMMAND_PULSE, data);
      csr_write(CSR_RESUME_DELAY, data);
      settings_applied++;
   endtask

   // Bursts of mostly ticks with the odd command, random gaps between bursts
   task automatic random_traffic(input int n, input int max_gap, input int cmd_pct);
      req_kind_type kind;
      cmd_code_type code;
      int           left;
      int           burst;
      left = n;
      while (left > 0) begin
         burst = $urandom_range(1, 16);
         if (burst > left)
            burst = left;
         left -= burst;
         repeat (burst) begin
            kind = ($urandom_range(0, 99) < cmd_pct) ? REQ_COMMAND : REQ_TICK;
            code = cmd_code_type'($urandom_range(0, 3));
            send_beat(kind, code);
         end
         idle_cycles($urandom_range(0, max_gap));
      end
   endtask

   // Every code, junk code on ticks, abandoned pulses, counts of one and zero
   task automatic test_directed_cases();
      send_beat(REQ_TICK, CMD_BAD);
      send_beat(REQ_COMMAND, CMD_OPEN);
      send_beat(REQ_TICK, CMD_CLOSE);
      send_beat(REQ_COMMAND, CMD_CLOSE);
      send_beat(REQ_COMMAND, CMD_AUTOCLOSE);
      send_beat(REQ_COMMAND, CMD_BAD);
      send_beat(REQ_TICK, CMD_OPEN);
      wait_for_results();
      csr_write(CSR_UNMAPPED_LO, DURATION_MAX);
      csr_write_all(16'd1);
      csr_write(CSR_UNMAPPED_HI, DURATION_MAX);
      send_beat(REQ_COMMAND, CMD_OPEN);
      repeat (4) send_beat(REQ_TICK, CMD_AUTOCLOSE);
      send_beat(REQ_COMMAND, CMD_BAD);
      wait_for_results();
      csr_write_all(16'd0);
      send_beat(REQ_COMMAND, CMD_AUTOCLOSE);
      repeat (3) send_beat(REQ_TICK, CMD_BAD);
      wait_for_results();
   endtask

   // Longest durations: nothing expires, commands still land
   task automatic test_register_extremes();
      csr_write_all(DURATION_MAX);
      send_beat(REQ_COMMAND, CMD_CLOSE);
      random_traffic(40, 3, 20);
      wait_for_results();
   endtask

   // Receiver holds off while the sender keeps offering beats
   task automatic test_input_backpressure();
      csr_write_all(16'd3);
      @(posedge clock);
      rsp_hold_request = 80;
      random_traffic(30, 0, 10);
      wait_for_results();
      random_traffic(10, 2, 10);
      wait_for_results();
   endtask

   // Several random settings, short durations mostly, both sides idling
   task automatic test_random_settings();
      int v;
      for (int p = 0; p < 6; p++) begin
         for (int r = CSR_WAKE_HIGH; r <= CSR_RESUME_DELAY; r++) begin
            v = $urandom_range(0, 19);
            if (v == 0)
               v = DURATION_MAX;
            else if (v < 5)
               v = 1;
            else
               v = $urandom_range(2, 12);
            csr_write(CSR_INDEX_BITS'(r), CSR_DATA_BITS'(v));
         end
         settings_applied++;
         // one phase runs flat out on both sides
         rsp_stalls_on = (p != 1);
         random_traffic(160, (p == 1) ? 0 : 6, 8);
         wait_for_results();
      end
      rsp_stalls_on = 1'b1;
   endtask

   // Receiver pacing: own on/off pattern, or a long hold when asked
   initial begin
      int hold_left;
      int on_left;
      int off_left;
      hold_left = 0;
      on_left   = 0;
      off_left  = 0;
      rsp_ready = 1'b1;
      forever begin
         @(negedge clock);
         if (rsp_hold_request != 0) begin
            hold_left        = rsp_hold_request;
            rsp_hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!rsp_stalls_on) begin
            rsp_ready <= 1'b1;
         end else begin
            if (on_left == 0 && off_left == 0) begin
               on_left  = $urandom_range(1, 8);
               off_left = $urandom_range(0, 4);
            end
            if (on_left > 0) begin
               on_left--;
               rsp_ready <= 1'b1;
            end else begin
               off_left--;
               rsp_ready <= 1'b0;
            end
         end
      end
   end

   task automatic compare_field(input string name, input logic want, input logic got);
      if (got !== want) begin
         $error("%s: expected %0b, got %0b", name, want, got);
         failures++;
      end
   endtask

   // Each result beat against the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (levels_due_q.size() == 0) begin
            $error("result beat with no expectation waiting");
            failures++;
         end else begin
            want = levels_due_q.pop_front();
            compare_field("open_level", want.open_level, rsp_open_level);
            compare_field("close_level", want.close_level, rsp_close_level);
            compare_field("autoclose_level", want.autoclose_level, rsp_autoclose_level);
            compare_field("rejected", want.rejected, rsp_rejected);
            beats_checked++;
         end
      end
   end

   // Run limit
   initial begin
      #5000000;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_type         = 1'b0;
      req_command_code = 2'd0;
      csr_valid        = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      rsp_hold_request = 0;
      rsp_stalls_on    = 1'b1;
      failures         = 0;
      beats_sent       = 0;
      beats_checked    = 0;
      req_stalls       = 0;
      settings_applied = 1;
      cfg.wake_high_ms     = WAKE_HIGH_RESET;
      cfg.wake_low_ms      = WAKE_LOW_RESET;
      cfg.command_pulse_ms = COMMAND_PULSE_RESET;
      cfg.resume_delay_ms  = RESUME_DELAY_RESET;
      wake_count   = WAKE_LOW_RESET;
      wake_armed   = 1'b1;
      wake_phase   = 1'b0;
      pulse_count  = '0;
      pulse_active = 1'b0;
      pulse_line   = '0;
      levels       = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_register_extremes();
      test_input_backpressure();
      test_random_settings();

      wait_for_results();
      repeat (8) @(posedge clock);
      if (levels_due_q.size() != 0) begin
         $error("%0d expected result beats never arrived", levels_due_q.size());
         failures++;
      end
      $display("Sent %0d request beats, checked %0d result beats over %0d register settings.",
               beats_sent, beats_checked, settings_applied);
      $display("Request side held off for %0d cycles by result back-pressure.", req_stalls);
      if (failures == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
